FILE: rtl/ccd_pkg.sv
// Shared types, constants and the character classifier for the cheat code decoder.
// Used by ccd_cell, ccd_decode and cheat_code_decoder_core; depends on nothing else.
package ccd_pkg;

    // Number of buffered characters.
    localparam int CHAR_DEPTH = 11;

    // Code lengths reported with a result.
    localparam logic [3:0] LEN_INVALID = 4'd0;
    localparam logic [3:0] LEN_SUB     = 4'd9;
    localparam logic [3:0] LEN_HEX16   = 4'd11;
    localparam logic [3:0] LEN_HEX8    = 4'd9;

    // Work RAM remapping for the eight-bit hex form.
    localparam logic [23:0] WRAM_BASE     = 24'hFF0000;
    localparam logic [1:0]  WRAM_LIMIT_HI = 2'b11;

    // Special characters.
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPA   = 8'h41;
    localparam logic [7:0] CHAR_UPF   = 8'h46;
    localparam logic [7:0] HEX_ALPHA_OFFSET = 8'h37;

    // Configuration register index of the mode register.
    localparam logic REG_MODE_IDX = 1'b0;

    // Symbol alphabet of the substitution form.
    localparam logic [7:0] SUB_ALPHABET [32] = '{
        "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N", "P", "R", "S",
        "T", "V", "W", "X", "Y", "Z", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9"
    };

    // Per-character classification kept in each cell.
    typedef struct packed {
        logic       sub_ok;
        logic [4:0] sub_idx;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       is_dash;
        logic       is_colon;
    } char_info_t;

    // Buffer length thresholds, counting the current character.
    typedef struct packed {
        logic ge7;
        logic ge9;
        logic ge11;
    } count_flags_t;

    // One decoded result.
    typedef struct packed {
        logic [15:0] data;
        logic [23:0] address;
        logic [3:0]  code_length;
    } result_t;

    // Classifies one character against both alphabets.
    function automatic char_info_t classify(input logic [7:0] c);
        char_info_t info;
        logic [7:0] diff;
        info = '0;
        diff = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (c == SUB_ALPHABET[i])
            begin
                info.sub_ok  = 1'b1;
                info.sub_idx = 5'(i);
            end
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            diff         = c - CHAR_ZERO;
            info.hex_ok  = 1'b1;
            info.hex_val = diff[3:0];
        end
        else if (c >= CHAR_UPA && c <= CHAR_UPF)
        begin
            diff         = c - HEX_ALPHA_OFFSET;
            info.hex_ok  = 1'b1;
            info.hex_val = diff[3:0];
        end
        info.is_dash  = (c == CHAR_DASH);
        info.is_colon = (c == CHAR_COLON);
        return info;
    endfunction

endpackage

FILE: rtl/cheat_code_decoder_core.sv
// Cheat code decoder: takes one character per cycle while the skid entry is empty,
// and registers a decoded code into the output stage once the final character is
// accepted. A row of eleven cells shifts the fill state one cell per character,
// and a two-entry output stage absorbs stalls.
// Reset clears the fill state, the mode register and the output stage; stored
// characters are not cleared. Depends on ccd_pkg, ccd_cell and ccd_decode.
module cheat_code_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // Character stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last_char
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] code_length, [27:4] address, [43:28] data, rest 0
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                  s_acc;
    logic                  m_acc;
    ccd_pkg::char_info_t   in_info;
    ccd_pkg::char_info_t   view [ccd_pkg::CHAR_DEPTH];
    logic [ccd_pkg::CHAR_DEPTH-1:0] filled_vec;
    ccd_pkg::count_flags_t flags;
    ccd_pkg::result_t      result;

    logic             mode_reg, mode_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    ccd_pkg::result_t out_reg, out_next;
    ccd_pkg::result_t skid_reg, skid_next;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;

    // Classify the incoming character once for all cells.
    assign in_info = ccd_pkg::classify(s_tdata);

    // Row of buffer cells; cell zero always has a filled neighbor.
    for (genvar i = 0; i < ccd_pkg::CHAR_DEPTH; i++)
    begin : g_cell
        ccd_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .accept      (s_acc),
            .last        (s_tlast),
            .prev_filled ((i == 0) ? 1'b1 : filled_vec[(i == 0) ? 0 : i - 1]),
            .in_info     (in_info),
            .filled      (filled_vec[i]),
            .view        (view[i])
        );
    end

    // Length thresholds including the current character.
    assign flags.ge7  = filled_vec[5];
    assign flags.ge9  = filled_vec[7];
    assign flags.ge11 = filled_vec[9];

    ccd_decode u_decode (
        .view           (view),
        .flags          (flags),
        .eight_bit_mode (mode_reg),
        .result         (result)
    );

    // Mode register write and readback.
    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && (paddr[2] == ccd_pkg::REG_MODE_IDX))
        begin
            mode_next = pwdata[0];
        end
    end

    assign prdata = (paddr[2] == ccd_pkg::REG_MODE_IDX) ? {31'd0, mode_reg} : 32'd0;
    assign pready = 1'b1;

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_acc)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (s_acc && s_tlast)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (s_acc && s_tlast)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

`ifndef SYNTHESIS
    // The fill state is a thermometer: no cell is filled past an empty one.
    a_fill_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        (filled_vec & ~{filled_vec[ccd_pkg::CHAR_DEPTH-2:0], 1'b1}) == '0)
        else $error("fill state is not contiguous");

    // A final character empties the buffer.
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tlast |=> filled_vec == '0)
        else $error("buffer not emptied after final character");

    // The skid entry is only occupied behind a full output register.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Only the defined code lengths leave the block.
    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.code_length == ccd_pkg::LEN_INVALID
                   || out_reg.code_length == ccd_pkg::LEN_SUB
                   || out_reg.code_length == ccd_pkg::LEN_HEX16))
        else $error("illegal code length");
`endif

endmodule

FILE: rtl/ccd_cell.sv
// One buffer cell of the cheat code decoder: holds one classified character and
// one bit of the fill thermometer. Depends on ccd_pkg.
module ccd_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                last,
    input  logic                prev_filled,
    input  ccd_pkg::char_info_t in_info,
    output logic                filled,
    output ccd_pkg::char_info_t view
);

    logic                filled_reg;
    logic                filled_next;
    ccd_pkg::char_info_t info_reg;
    logic                wr_en;

    // This cell is the next free slot when its left neighbor is filled and it is not.
    assign wr_en = accept && prev_filled && !filled_reg;

    // The fill bit shifts in from the left neighbor and clears after a final character.
    always_comb
    begin
        filled_next = filled_reg;
        if (accept)
        begin
            filled_next = last ? 1'b0 : prev_filled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    // Character storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            info_reg <= in_info;
        end
    end

    // The decoder sees the character being written in this cycle.
    assign view   = wr_en ? in_info : info_reg;
    assign filled = filled_reg;

endmodule

FILE: rtl/ccd_decode.sv
// Decoder of the buffered code string into address, data and code length.
// Depends on ccd_pkg.
module ccd_decode (
    input  ccd_pkg::char_info_t   view [ccd_pkg::CHAR_DEPTH],
    input  ccd_pkg::count_flags_t flags,
    input  logic                  eight_bit_mode,
    output ccd_pkg::result_t      result
);

    logic [4:0]  n0, n1, n2, n3, n4, n5, n6, n7;
    logic        sub_sel, sub_ok;
    logic        hex_sel, hex16_ok, hex8_ok;
    logic [23:0] sub_addr;
    logic [15:0] sub_data;
    logic [15:0] hex8_addr;

    // Substitution symbols skip the dash at position four.
    assign n0 = view[0].sub_idx;
    assign n1 = view[1].sub_idx;
    assign n2 = view[2].sub_idx;
    assign n3 = view[3].sub_idx;
    assign n4 = view[5].sub_idx;
    assign n5 = view[6].sub_idx;
    assign n6 = view[7].sub_idx;
    assign n7 = view[8].sub_idx;

    assign sub_sel = flags.ge9 && view[4].is_dash;
    assign sub_ok  = view[0].sub_ok && view[1].sub_ok && view[2].sub_ok && view[3].sub_ok
                  && view[5].sub_ok && view[6].sub_ok && view[7].sub_ok && view[8].sub_ok;

    // Scatter of the symbol bits into address and data.
    assign sub_addr = {n3[3:0], n4[4:1], n1[1:0], n2, n3[4], n6[2:0], n7};
    assign sub_data = {n5[0], n6[4:3], n4[0], n5[4:1], n0, n1[4:2]};

    assign hex_sel  = flags.ge7 && view[6].is_colon;
    assign hex16_ok = flags.ge11
                   && view[0].hex_ok && view[1].hex_ok && view[2].hex_ok
                   && view[3].hex_ok && view[4].hex_ok && view[5].hex_ok
                   && view[7].hex_ok && view[8].hex_ok && view[9].hex_ok
                   && view[10].hex_ok;

    assign hex8_addr = {view[2].hex_val, view[3].hex_val, view[4].hex_val, view[5].hex_val};
    assign hex8_ok   = flags.ge9
                    && view[2].hex_ok && view[3].hex_ok && view[4].hex_ok
                    && view[5].hex_ok && view[7].hex_ok && view[8].hex_ok
                    && (hex8_addr[15:14] == ccd_pkg::WRAM_LIMIT_HI);

    // Form selection; any failed check leaves an all-zero result.
    always_comb
    begin
        result = '0;
        if (sub_sel)
        begin
            if (!eight_bit_mode && sub_ok)
            begin
                result.code_length = ccd_pkg::LEN_SUB;
                result.address     = sub_addr;
                result.data        = sub_data;
            end
        end
        else if (hex_sel)
        begin
            if (!eight_bit_mode)
            begin
                if (hex16_ok)
                begin
                    result.code_length = ccd_pkg::LEN_HEX16;
                    result.address     = {view[0].hex_val, view[1].hex_val,
                                          view[2].hex_val, view[3].hex_val,
                                          view[4].hex_val, view[5].hex_val};
                    result.data        = {view[7].hex_val, view[8].hex_val,
                                          view[9].hex_val, view[10].hex_val};
                end
            end
            else if (hex8_ok)
            begin
                result.code_length = ccd_pkg::LEN_HEX8;
                result.address     = ccd_pkg::WRAM_BASE | {11'd0, hex8_addr[12:0]};
                result.data        = {8'd0, view[7].hex_val, view[8].hex_val};
            end
        end
    end

endmodule
